/* hw/rtl/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg
// shared types, widths, register indexes and the 32-bit clip function
// ----------------------------------------------------------------------------
package spl_pkg;

	localparam int DATA_W    = 32;
	localparam int RAW_W     = 16;
	localparam int OFFSET_W  = 24;
	localparam int FRAC_IN   = 8;
	localparam int DIFF_W    = 26;
	localparam int XPROD_W   = DIFF_W + DATA_W;
	localparam int WIDE_W    = 2 * DATA_W;
	localparam int X_SHIFT   = 8;
	localparam int P_SHIFT   = 30;
	localparam int NUM_CELLS = 5;
	localparam int NUM_COEF  = NUM_CELLS + 1;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SCALE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG5      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG4      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG3      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG2      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG1      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG0      = 3'd7;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] acc;
		logic                     sat;
	} spl_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     clip;
	} spl_clip_t;

	function automatic spl_clip_t spl_clip(input logic signed [WIDE_W-1:0] v);
		spl_clip_t r;
		if (v > WIDE_W'(DATA_MAX)) begin
			r.val  = DATA_MAX;
			r.clip = 1'b1;
		end else if (v < WIDE_W'(DATA_MIN)) begin
			r.val  = DATA_MIN;
			r.clip = 1'b1;
		end else begin
			r.val  = v[DATA_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/sensor_poly_linearizer.sv */
// ----------------------------------------------------------------------------
// sensor_poly_linearizer
// raw reading minus offset, times input scale, then a degree-5 polynomial by
// Horner's rule over a row of five cells, saturating Q8.24 result and flag
//
// channel  signals                                      role
// in       in_valid, in_ready, raw_reading              one reading per beat
// out      out_valid, out_ready, observation, saturated one result per beat
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data    register writes
//
// one beat per cycle while out_ready is high; 3 front stages, 2 per cell
// every stage has its own valid bit and moves when the next one is empty or
// moving, so bubbles close up and a stalled output still lets beats enter
// a full pipeline with out_ready low stalls everything back to in_ready
// reset clears the stage valid bits and loads the register reset values
// cfg_ready is always high; writes take effect in the next cycle
// ----------------------------------------------------------------------------
module sensor_poly_linearizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [spl_pkg::RAW_W-1:0]          raw_reading,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [spl_pkg::DATA_W-1:0]  observation,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spl_pkg::DATA_W-1:0]         cfg_data
);
	import spl_pkg::*;

	logic signed [OFFSET_W-1:0] zero_offset_q;
	logic signed [DATA_W-1:0]   input_scale_q;
	logic signed [DATA_W-1:0]   coef_q [NUM_COEF];

	logic                       link_valid [NUM_CELLS+1];
	logic                       link_ready [NUM_CELLS+1];
	spl_beat_t                  link_beat  [NUM_CELLS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= '0;
			input_scale_q <= DATA_W'(32'sh4000_0000);
			coef_q[0]     <= '0;
			coef_q[1]     <= '0;
			coef_q[2]     <= '0;
			coef_q[3]     <= '0;
			coef_q[4]     <= DATA_W'(32'sh0100_0000);
			coef_q[5]     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ZERO_OFFSET: zero_offset_q <= cfg_data[OFFSET_W-1:0];
				CFG_INPUT_SCALE: input_scale_q <= cfg_data;
				CFG_COEF_DEG5:   coef_q[0]     <= cfg_data;
				CFG_COEF_DEG4:   coef_q[1]     <= cfg_data;
				CFG_COEF_DEG3:   coef_q[2]     <= cfg_data;
				CFG_COEF_DEG2:   coef_q[3]     <= cfg_data;
				CFG_COEF_DEG1:   coef_q[4]     <= cfg_data;
				CFG_COEF_DEG0:   coef_q[5]     <= cfg_data;
				default:         zero_offset_q <= zero_offset_q;
			endcase
		end
	end

	spl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.zero_offset (zero_offset_q),
		.input_scale (input_scale_q),
		.coef_lead   (coef_q[0]),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_reading (raw_reading),
		.out_valid   (link_valid[0]),
		.out_ready   (link_ready[0]),
		.out_beat    (link_beat[0])
	);

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		spl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.coef      (coef_q[k+1]),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_beat   (link_beat[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_beat  (link_beat[k+1])
		);
	end

	assign link_ready[NUM_CELLS] = out_ready;
	assign out_valid             = link_valid[NUM_CELLS];
	assign observation           = link_beat[NUM_CELLS].acc;
	assign saturated             = link_beat[NUM_CELLS].sat;

	a_cfg_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == CFG_ZERO_OFFSET)
		|=> (zero_offset_q == $past(cfg_data[OFFSET_W-1:0])))
		else $error("offset write not taken");

	a_cfg_scale_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_index == CFG_INPUT_SCALE) |=> $stable(input_scale_q))
		else $error("input scale changed without a write");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready)
		|=> (out_valid && $stable(observation) && $stable(saturated)))
		else $error("result changed while stalled");

endmodule

/* hw/rtl/spl_front.sv */
// ----------------------------------------------------------------------------
// spl_front
// offset removal and input scaling, three stages, gives x in Q2.30 and the
// leading coefficient as the first Horner accumulator
// ----------------------------------------------------------------------------
module spl_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [spl_pkg::OFFSET_W-1:0]   zero_offset,
	input  logic signed [spl_pkg::DATA_W-1:0]     input_scale,
	input  logic signed [spl_pkg::DATA_W-1:0]     coef_lead,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [spl_pkg::RAW_W-1:0]             raw_reading,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output spl_pkg::spl_beat_t                    out_beat
);
	import spl_pkg::*;

	logic                      v1_q, v2_q, v3_q;
	logic                      rdy1, rdy2, rdy3;
	logic signed [DIFF_W-1:0]  diff_s1;
	logic signed [XPROD_W-1:0] prod_s2;
	spl_beat_t                 beat_s3;
	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [XPROD_W-1:0] prod_c;
	logic signed [XPROD_W-1:0] rsum_c;
	logic signed [XPROD_W-1:0] shr_c;
	spl_clip_t                 xclip_c;

	assign rdy3     = !v3_q || out_ready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		diff_c  = $signed({2'b00, raw_reading, {FRAC_IN{1'b0}}}) - DIFF_W'(zero_offset);
		prod_c  = diff_s1 * input_scale;
		rsum_c  = prod_s2 + (XPROD_W'(1) <<< (X_SHIFT - 1));
		shr_c   = rsum_c >>> X_SHIFT;
		xclip_c = spl_clip(WIDE_W'(shr_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) diff_s1 <= diff_c;
		if (rdy2 && v1_q) prod_s2 <= prod_c;
		if (rdy3 && v2_q) begin
			beat_s3.x   <= xclip_c.val;
			beat_s3.acc <= coef_lead;
			beat_s3.sat <= xclip_c.clip;
		end
	end

	assign out_valid = v3_q;
	assign out_beat  = beat_s3;

	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && beat_s3.sat) |-> (beat_s3.x == DATA_MAX || beat_s3.x == DATA_MIN))
		else $error("x flagged as clipped but not at a rail");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && rdy2) |=> (v2_q && prod_s2 == $past(diff_s1) * $past(input_scale)))
		else $error("scaling stage lost or altered a beat");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && !out_ready) |=> (v3_q && $stable(beat_s3)))
		else $error("front output changed while stalled");

endmodule

/* hw/rtl/spl_cell.sv */
// ----------------------------------------------------------------------------
// spl_cell
// one Horner step: acc * x rounded and clipped, plus a coefficient, clipped;
// two stages, multiply then round/add
// ----------------------------------------------------------------------------
module spl_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [spl_pkg::DATA_W-1:0] coef,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spl_pkg::spl_beat_t                in_beat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output spl_pkg::spl_beat_t                out_beat
);
	import spl_pkg::*;

	logic                     v1_q, v2_q;
	logic                     rdy1, rdy2;
	logic signed [WIDE_W-1:0] mul_s1;
	logic signed [DATA_W-1:0] x_s1;
	logic                     sat_s1;
	spl_beat_t                beat_s2;
	logic signed [WIDE_W-1:0] mul_c;
	logic signed [WIDE_W-1:0] rsum_c;
	logic signed [WIDE_W-1:0] shr_c;
	spl_clip_t                pclip_c;
	logic signed [DATA_W:0]   sum_c;
	spl_clip_t                sclip_c;

	assign rdy2     = !v2_q || out_ready;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		mul_c   = in_beat.acc * in_beat.x;
		rsum_c  = mul_s1 + (WIDE_W'(1) <<< (P_SHIFT - 1));
		shr_c   = rsum_c >>> P_SHIFT;
		pclip_c = spl_clip(shr_c);
		sum_c   = (DATA_W+1)'(pclip_c.val) + (DATA_W+1)'(coef);
		sclip_c = spl_clip(WIDE_W'(sum_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mul_s1 <= mul_c;
			x_s1   <= in_beat.x;
			sat_s1 <= in_beat.sat;
		end
		if (rdy2 && v1_q) begin
			beat_s2.x   <= x_s1;
			beat_s2.acc <= sclip_c.val;
			beat_s2.sat <= sat_s1 | pclip_c.clip | sclip_c.clip;
		end
	end

	assign out_valid = v2_q;
	assign out_beat  = beat_s2;

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && rdy2 && sat_s1) |=> beat_s2.sat)
		else $error("saturation flag dropped in cell");

	a_x_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && rdy2) |=> (v2_q && beat_s2.x == $past(x_s1)))
		else $error("x not handed on unchanged");

	a_clean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && rdy2 && !pclip_c.clip && !sclip_c.clip && !sat_s1) |=> !beat_s2.sat)
		else $error("flag set without clipping");

endmodule

/* verif/sensor_poly_linearizer_tb.sv */
// ----------------------------------------------------------------------------
// sensor_poly_linearizer_tb
// drives raw readings through the linearizer under random input gaps and
// output stalls, checks each result against a fixed-point Horner model kept
// in the bench or the table; a directed table covers reset values, register
// extremes and clipping, then random phases, each with a fresh register set
// ----------------------------------------------------------------------------
module sensor_poly_linearizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spl_pkg::*;

	localparam int PIPE_DEPTH   = 13;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 107;
	localparam int PLAN_LEN     = 35;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {MODE_CAL, MODE_EDGE, MODE_WILD} phase_mode_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] obs;
		logic                     sat;
	} linearized_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     index;
		logic [DATA_W-1:0]        data;
		logic [RAW_W-1:0]         raw;
		logic                     known;
		logic signed [DATA_W-1:0] obs;
		logic                     sat;
	} plan_row_t;

	localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
		'{ROW_ITEM, '0, '0, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h0001, 1'b1, 32'h0100_0000, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h0002, 1'b1, 32'h0200_0000, 1'b1},
		'{ROW_ITEM, '0, '0, 16'hFFFF, 1'b1, 32'h0200_0000, 1'b1},
		'{ROW_ITEM, '0, '0, 16'h5555, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'hAAAA, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_ZERO_OFFSET,    32'hFF7F_FF00, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_INPUT_SCALE,    32'h0000_8000, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h0000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h7FFF, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h8000, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'hFFFF, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG5, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG4, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG3, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG2, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG1, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG0, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'hFFFF, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h0000, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG5, 32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG4, 32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG3, 32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG2, 32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG1, 32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_COEF_DEG0, 32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'hFFFF, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h0000, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_ZERO_OFFSET,    32'hA580_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_INPUT_SCALE,    32'h8000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'hFFFF, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_INPUT_SCALE,    32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h0000, 1'b0, '0, 1'b0},
		'{ROW_CFG, CFG_INPUT_SCALE,    32'h0000_0000, '0, 1'b0, '0, 1'b0},
		'{ROW_ITEM, '0, '0, 16'h1234, 1'b1, 32'h8000_0000, 1'b0}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [RAW_W-1:0]            raw_reading;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [DATA_W-1:0]    observation;
	logic                        saturated;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [DATA_W-1:0]           cfg_data;

	longint      offset_q;
	longint      scale_q;
	longint      coef_q [NUM_COEF];
	linearized_t pending_obs [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          gapless;

	sensor_poly_linearizer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_reading (raw_reading),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.observation (observation),
		.saturated   (saturated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(input longint v, inout bit flag);
		if (v > longint'(DATA_MAX)) begin
			flag = 1'b1;
			return longint'(DATA_MAX);
		end
		if (v < longint'(DATA_MIN)) begin
			flag = 1'b1;
			return longint'(DATA_MIN);
		end
		return v;
	endfunction

	function automatic linearized_t linearize(input logic [RAW_W-1:0] raw);
		linearized_t r;
		longint      d;
		longint      x;
		longint      acc;
		longint      p;
		bit          clip;
		clip = 1'b0;
		d    = longint'(raw) * 256 - offset_q;
		x    = clip32(round_shift(d * scale_q, X_SHIFT), clip);
		acc  = coef_q[0];
		for (int k = 1; k < NUM_COEF; k++) begin
			p   = clip32(round_shift(acc * x, P_SHIFT), clip);
			acc = clip32(p + coef_q[k], clip);
		end
		r.obs = acc[DATA_W-1:0];
		r.sat = clip;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] data);
		logic signed [OFFSET_W-1:0] off;
		off = data[OFFSET_W-1:0];
		case (idx)
			CFG_ZERO_OFFSET: offset_q = off;
			CFG_INPUT_SCALE: scale_q  = $signed(data);
			default:         coef_q[idx - CFG_COEF_DEG5] = $signed(data);
		endcase
	endfunction

	function automatic int idle_cycles();
		return gapless ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic [RAW_W-1:0] random_reading();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return RAW_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_reg_value(input phase_mode_t mode,
		input logic [CFG_IDX_W-1:0] idx);
		logic [DATA_W-1:0] v;
		int                s;
		v = $urandom;
		if (idx == CFG_ZERO_OFFSET) begin
			case (mode)
				MODE_CAL: v[OFFSET_W-1:0] = OFFSET_W'($urandom_range(0, 24'h7F_FFFF));
				MODE_EDGE: begin
					case ($urandom_range(0, 2))
						0:       v[OFFSET_W-1:0] = 24'h80_0000;
						1:       v[OFFSET_W-1:0] = 24'h7F_FFFF;
						default: v[OFFSET_W-1:0] = '0;
					endcase
				end
				default: ;
			endcase
		end else if (idx == CFG_INPUT_SCALE && mode == MODE_CAL) begin
			s = $urandom_range(1 << 13, 1 << 15);
			v = $urandom_range(0, 1) ? -s : s;
		end else if (mode == MODE_CAL) begin
			v = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		end else if (mode == MODE_EDGE) begin
			case ($urandom_range(0, 3))
				0:       v = DATA_MIN;
				1:       v = DATA_MAX;
				2:       v = '0;
				default: ;
			endcase
		end
		return v;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic push_reading(input logic [RAW_W-1:0] raw, input bit known,
		input linearized_t typed);
		int          gap;
		linearized_t want;
		gap  = idle_cycles();
		want = known ? typed : linearize(raw);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		raw_reading <= raw;
		do @(posedge clk); while (!in_ready);
		pending_obs.push_back(want);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
	endtask

	// lets the pipeline empty before registers change
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_obs.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	task automatic run_phase(input phase_mode_t mode);
		settle();
		for (int i = 0; i < NUM_COEF + 2; i++)
			write_reg(CFG_IDX_W'(i), pick_reg_value(mode, CFG_IDX_W'(i)));
		cfg_valid <= 1'b0;
		@(negedge clk);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n % 25 == 0)
				gapless = ($urandom_range(0, 3) == 0);
			push_reading(random_reading(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : check_beats
		linearized_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_obs.size() == 0) begin
				note_mismatch($sformatf("beat with nothing pending, observation %h",
					observation));
			end else begin
				want = pending_obs.pop_front();
				if (observation !== want.obs)
					note_mismatch($sformatf("observation %h, want %h", observation, want.obs));
				if (saturated !== want.sat)
					note_mismatch($sformatf("saturated %b, want %b", saturated, want.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("sensor_poly_linearizer_tb failed");
			$finish;
		end
	end

	// result side stalls
	initial begin : drain_side
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		bit cfg_open;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		raw_reading = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		gapless     = 1'b0;
		cfg_open    = 1'b0;
		offset_q    = 0;
		scale_q     = longint'(1) << 30;
		coef_q      = '{0, 0, 0, 0, longint'(1) << 24, 0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					settle();
					cfg_open = 1'b1;
				end
				write_reg(PLAN[i].index, PLAN[i].data);
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					@(negedge clk);
					cfg_open = 1'b0;
				end
				push_reading(PLAN[i].raw, PLAN[i].known, {PLAN[i].obs, PLAN[i].sat});
			end
		end

		run_phase(MODE_CAL);
		run_phase(MODE_EDGE);
		run_phase(MODE_CAL);
		run_phase(MODE_WILD);
		run_phase(MODE_CAL);

		settle();
		if (mismatches == 0 && pending_obs.size() == 0) begin
			$display("sensor_poly_linearizer_tb passed");
		end else begin
			$display("sensor_poly_linearizer_tb failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/spl_pkg.sv
hw/rtl/spl_front.sv
hw/rtl/spl_cell.sv
hw/rtl/sensor_poly_linearizer.sv
verif/sensor_poly_linearizer_tb.sv
